### hw/rtl/fac_pkg.sv
// Shared types and constants for the frustum box cull block.
`default_nettype none

package fac_pkg;

  localparam int PLANE_COUNT   = 6;
  localparam int AXIS_COUNT    = 3;
  localparam int MATRIX_DIM    = 4;
  localparam int ELEMENT_COUNT = MATRIX_DIM * MATRIX_DIM;
  localparam int INDEX_WIDTH   = $clog2(ELEMENT_COUNT);

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TEST = 1'b1
  } cmd_t;

  // Plane component = col_a +/- col_b (col_b negative: col_a alone).
  // Order: left, right, top, bottom, near, far. Columns counted from 0.
  localparam int PLANE_COL_A [PLANE_COUNT] = '{3, 3, 3, 3, 2, 3};
  localparam int PLANE_COL_B [PLANE_COUNT] = '{0, 0, 1, 1, -1, 2};
  localparam bit PLANE_NEG   [PLANE_COUNT] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

endpackage

`default_nettype wire

### hw/rtl/fac_if.sv
// Request and response channel interfaces for the frustum box cull block.
`default_nettype none

interface fac_req_if
  import fac_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  cmd_t                          command;
  logic [INDEX_WIDTH-1:0]        element_index;
  logic signed [VALUE_WIDTH-1:0] element_value;
  logic signed [VALUE_WIDTH-1:0] box_min_x;
  logic signed [VALUE_WIDTH-1:0] box_min_y;
  logic signed [VALUE_WIDTH-1:0] box_min_z;
  logic signed [VALUE_WIDTH-1:0] box_max_x;
  logic signed [VALUE_WIDTH-1:0] box_max_y;
  logic signed [VALUE_WIDTH-1:0] box_max_z;
  logic                          always_visible;

  modport source (
    output valid, command, element_index, element_value,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
           always_visible,
    input  ready
  );

  modport sink (
    input  valid, command, element_index, element_value,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
           always_visible,
    output ready
  );
endinterface

interface fac_rsp_if;
  logic valid;
  logic ready;
  logic culled;

  modport source (output valid, culled, input ready);
  modport sink   (input valid, culled, output ready);
endinterface

`default_nettype wire

### hw/rtl/frustum_aabb_cull_top.sv
// Top level of the view frustum culling block for axis-aligned boxes.
`default_nettype none

// Frustum box cull. A load request writes one element of the 4x4
// view-projection matrix (index = row*4 + column, both from zero) and gives
// no response; a test request checks one world-space box against the six
// planes derived from the matrix and gives exactly one response with the
// culled flag. One request is taken every cycle while no response waits
// on rsp; a test's response passes the input register, product register
// and result register and is shown on rsp in request order. A load
// affects any test accepted after it, including one in the very next
// cycle. Pace is set by the logic feeding the product register, where
// each of the 18 plane/axis pairs has its own (VALUE_WIDTH+1) by
// VALUE_WIDTH signed multiplier. The whole pipe stalls together while a
// response waits, so req.ready follows rsp.ready combinationally. The
// matrix has no reset: all 16 elements must be loaded before the first
// test.
module frustum_aabb_cull_top
  import fac_pkg::*;
#(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  fac_req_if.sink   req,
  fac_rsp_if.source rsp
);

  // Plane component: sum of two elements. Product: component times corner.
  // Sum: three products plus the shifted offset, with room for carries.
  localparam int COMP_WIDTH = VALUE_WIDTH + 1;
  localparam int PROD_WIDTH = COMP_WIDTH + VALUE_WIDTH;
  localparam int SUM_WIDTH  = PROD_WIDTH + 2;

  // ---------------------------------------------------------------------
  // Handshake: the pipe moves as one whenever the result slot is free.
  // ---------------------------------------------------------------------
  logic advance;
  logic accept;
  logic out_valid;
  logic culled;

  assign advance   = !out_valid || rsp.ready;
  assign accept    = req.valid && advance;
  assign req.ready = advance;
  assign rsp.valid = out_valid;
  assign rsp.culled = culled;

  // ---------------------------------------------------------------------
  // Matrix store, written straight from the request port.
  // ---------------------------------------------------------------------
  logic signed [VALUE_WIDTH-1:0] matrix [ELEMENT_COUNT];

  always_ff @(posedge clk) begin
    if (accept && req.command == CMD_LOAD) begin
      matrix[req.element_index] <= req.element_value;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: registered test request.
  // ---------------------------------------------------------------------
  logic                          s1_valid;
  logic                          s1_visible;
  logic signed [VALUE_WIDTH-1:0] box_min [AXIS_COUNT];
  logic signed [VALUE_WIDTH-1:0] box_max [AXIS_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept && req.command == CMD_TEST;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_visible <= req.always_visible;
      box_min[0] <= req.box_min_x;
      box_min[1] <= req.box_min_y;
      box_min[2] <= req.box_min_z;
      box_max[0] <= req.box_max_x;
      box_max[1] <= req.box_max_y;
      box_max[2] <= req.box_max_z;
    end
  end

  // Plane components from the current matrix; row 3 is the offset d.
  // The farthest corner along the normal takes the minimum where the
  // component is negative, else the maximum (zero picks the maximum).
  logic signed [COMP_WIDTH-1:0]  comp      [PLANE_COUNT][MATRIX_DIM];
  logic signed [VALUE_WIDTH-1:0] corner    [PLANE_COUNT][AXIS_COUNT];
  logic signed [PROD_WIDTH-1:0]  prod_next [PLANE_COUNT][AXIS_COUNT];

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    for (genvar r = 0; r < MATRIX_DIM; r++) begin : g_row
      if (PLANE_COL_B[p] < 0) begin : g_single
        assign comp[p][r] = COMP_WIDTH'(matrix[r*MATRIX_DIM + PLANE_COL_A[p]]);
      end else if (PLANE_NEG[p]) begin : g_diff
        assign comp[p][r] = COMP_WIDTH'(matrix[r*MATRIX_DIM + PLANE_COL_A[p]])
                          - COMP_WIDTH'(matrix[r*MATRIX_DIM + PLANE_COL_B[p]]);
      end else begin : g_sum
        assign comp[p][r] = COMP_WIDTH'(matrix[r*MATRIX_DIM + PLANE_COL_A[p]])
                          + COMP_WIDTH'(matrix[r*MATRIX_DIM + PLANE_COL_B[p]]);
      end
    end
    for (genvar k = 0; k < AXIS_COUNT; k++) begin : g_axis
      assign corner[p][k]    = comp[p][k][COMP_WIDTH-1] ? box_min[k] : box_max[k];
      assign prod_next[p][k] = PROD_WIDTH'(comp[p][k]) * PROD_WIDTH'(corner[p][k]);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: registered products and offsets.
  // ---------------------------------------------------------------------
  logic                         s2_valid;
  logic                         s2_visible;
  logic signed [PROD_WIDTH-1:0] prod   [PLANE_COUNT][AXIS_COUNT];
  logic signed [COMP_WIDTH-1:0] offset [PLANE_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_visible <= s1_visible;
      for (int p = 0; p < PLANE_COUNT; p++) begin
        offset[p] <= comp[p][MATRIX_DIM-1];
        for (int k = 0; k < AXIS_COUNT; k++) begin
          prod[p][k] <= prod_next[p][k];
        end
      end
    end
  end

  // Plane distance at double fraction; only its sign matters.
  logic signed [SUM_WIDTH-1:0] offset_ext [PLANE_COUNT];
  logic signed [SUM_WIDTH-1:0] plane_dist [PLANE_COUNT];
  logic [PLANE_COUNT-1:0]      behind;
  logic                        culled_next;

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_dist
    assign offset_ext[p] = SUM_WIDTH'(offset[p]);
    assign plane_dist[p] = (offset_ext[p] <<< FRACTION_BITS)
                         + SUM_WIDTH'(prod[p][0])
                         + SUM_WIDTH'(prod[p][1])
                         + SUM_WIDTH'(prod[p][2]);
    assign behind[p] = plane_dist[p][SUM_WIDTH-1];
  end

  assign culled_next = (|behind) && !s2_visible;

  // ---------------------------------------------------------------------
  // Stage 3: result register.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      culled <= culled_next;
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  load_no_response: assert property (@(posedge clk) disable iff (rst)
    (accept && req.command == CMD_LOAD) |=> !s1_valid)
    else $error("load request entered the test pipe");

  pipe_no_drop: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance) |=> s2_valid)
    else $error("test request lost between stages");

  visible_never_culled: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_visible && advance) |=> (out_valid && !culled))
    else $error("always-visible box reported culled");

endmodule

`default_nettype wire
